/* rtl/core/m3inv_pkg.sv */
// Package with types, widths and helpers shared by the 3x3 matrix inverse core.
`default_nettype none
package m3inv_pkg;

    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int ProdWidth = 2 * DataWidth;
    localparam int CofWidth  = ProdWidth + 1;
    localparam int DetWidth  = DataWidth + CofWidth + 2;
    localparam int NumWidth  = CofWidth + 2 * FracBits;
    localparam int MagWidth  = NumWidth;
    localparam int DivMagW   = DetWidth;
    localparam int QuotWidth = NumWidth;
    localparam int NumLanes  = 9;

    typedef logic signed [DataWidth-1:0] elem_t;
    typedef logic signed [CofWidth-1:0]  cof_t;
    typedef logic signed [DetWidth-1:0]  det_t;

    typedef struct packed {
        elem_t a00;
        elem_t a01;
        elem_t a02;
        elem_t a10;
        elem_t a11;
        elem_t a12;
        elem_t a20;
        elem_t a21;
        elem_t a22;
    } mat_in_t;

    typedef struct packed {
        elem_t b00;
        elem_t b01;
        elem_t b02;
        elem_t b10;
        elem_t b11;
        elem_t b12;
        elem_t b20;
        elem_t b21;
        elem_t b22;
        logic  singular;
        logic  saturated;
    } mat_out_t;

    typedef struct packed {
        logic [MagWidth-1:0] num_mag;
        logic                neg;
    } lane_in_t;

    typedef struct packed {
        elem_t value;
        logic  sat;
    } lane_out_t;

endpackage
`default_nettype wire

/* rtl/core/matrix_3x3_inverse_core.sv */
// Top level of the 3x3 matrix inverse core: cofactor front end, nine divider lanes, merge.
//
// One beat on the input (start high while busy is low) carries a whole 3x3 Q16.16 matrix.
// One beat on the output (done high for one cycle) carries the inverse, the singular flag
// and the saturated flag. busy is always low: a new matrix may enter every cycle.
// The result passes 4 + 1 + 98 + 1 register stages: four stages of cofactor and determinant
// products, a sign-magnitude stage, an input register plus one restoring-divider stage per
// quotient bit in each of nine parallel lanes, and a merge register. Throughput is one
// matrix per cycle.
// A zero determinant gives all-zero elements with singular set.
// Reset clears only the valid pipeline; no beat appears until a matrix is taken.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module matrix_3x3_inverse_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire m3inv_pkg::mat_in_t    mat_in,
    output logic                       done,
    output m3inv_pkg::mat_out_t        mat_out
);

    localparam int QW = m3inv_pkg::QuotWidth;

    logic                                          cof_valid;
    m3inv_pkg::cof_t [m3inv_pkg::NumLanes-1:0]     cof;
    m3inv_pkg::det_t                               det;
    m3inv_pkg::lane_in_t                           lin_reg [m3inv_pkg::NumLanes];
    logic [m3inv_pkg::DivMagW-1:0]                 den_reg;
    logic                                          sing_pipe_reg [QW+2];
    logic [QW+1:0]                                 vld_reg;
    m3inv_pkg::lane_out_t                          lout [m3inv_pkg::NumLanes];
    m3inv_pkg::mat_out_t                           res_reg;
    m3inv_pkg::mat_out_t                           res_next;
    logic                                          done_reg;

    assign busy = 1'b0;

    m3inv_cof u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .mat       (mat_in),
        .out_valid (cof_valid),
        .cof       (cof),
        .det       (det)
    );

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < m3inv_pkg::NumLanes; k++)
        begin
            lin_reg[k].num_mag <= cof[k][m3inv_pkg::CofWidth-1]
                ? m3inv_pkg::MagWidth'(-(m3inv_pkg::MagWidth'(signed'(cof[k])))) <<
                  (2 * m3inv_pkg::FracBits)
                : m3inv_pkg::MagWidth'(signed'(cof[k])) << (2 * m3inv_pkg::FracBits);
            lin_reg[k].neg <= cof[k][m3inv_pkg::CofWidth-1] ^ det[m3inv_pkg::DetWidth-1];
        end
        den_reg <= det[m3inv_pkg::DetWidth-1] ? m3inv_pkg::DivMagW'(-det)
                                              : m3inv_pkg::DivMagW'(det);
        sing_pipe_reg[0] <= (det == '0);
        for (int s = 0; s <= QW; s++)
        begin
            sing_pipe_reg[s+1] <= sing_pipe_reg[s];
        end
        res_reg <= res_next;
    end

    genvar g;
    generate
        for (g = 0; g < m3inv_pkg::NumLanes; g++)
        begin : g_lane
            m3inv_div u_div (
                .clk      (clk),
                .lane_in  (lin_reg[g]),
                .den      (den_reg),
                .lane_out (lout[g])
            );
        end
    endgenerate

    always_comb
    begin
        res_next = '0;
        if (sing_pipe_reg[QW+1])
        begin
            res_next.singular = 1'b1;
        end
        else
        begin
            res_next.b00 = lout[0].value;
            res_next.b10 = lout[1].value;
            res_next.b20 = lout[2].value;
            res_next.b01 = lout[3].value;
            res_next.b11 = lout[4].value;
            res_next.b21 = lout[5].value;
            res_next.b02 = lout[6].value;
            res_next.b12 = lout[7].value;
            res_next.b22 = lout[8].value;
            res_next.saturated = lout[0].sat | lout[1].sat | lout[2].sat | lout[3].sat
                               | lout[4].sat | lout[5].sat | lout[6].sat | lout[7].sat
                               | lout[8].sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[QW:0], cof_valid};
            done_reg <= vld_reg[QW+1];
        end
    end

    assign done    = done_reg;
    assign mat_out = res_reg;

`ifndef SYNTHESIS
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && mat_out.singular |-> mat_out.b00 == '0 && mat_out.b11 == '0
                                     && !mat_out.saturated)
        else $error("singular result with nonzero data");
    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vld_reg[QW+1]))
        else $error("done without pipeline valid");
`endif

endmodule
`default_nettype wire

/* rtl/core/m3inv_cof.sv */
// Front end: cofactors and determinant, registered over four stages.
`default_nettype none
module m3inv_cof (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         in_valid,
    input  wire m3inv_pkg::mat_in_t                           mat,
    output logic                                              out_valid,
    output m3inv_pkg::cof_t [m3inv_pkg::NumLanes-1:0]         cof,
    output m3inv_pkg::det_t                                   det
);

    typedef logic signed [m3inv_pkg::ProdWidth-1:0] prod_t;
    typedef logic signed [m3inv_pkg::ProdWidth:0]   pprod_t;
    typedef logic signed [m3inv_pkg::DetWidth-1:0]  dprod_t;

    m3inv_pkg::elem_t m [3][3];
    prod_t            p1_reg [9];
    prod_t            p2_reg [9];
    m3inv_pkg::elem_t row0_reg [3];
    m3inv_pkg::cof_t  cof_reg [9];
    m3inv_pkg::elem_t row0b_reg [3];
    pprod_t           pl_reg [3];
    pprod_t           ph_reg [3];
    m3inv_pkg::cof_t  cofb_reg [9];
    dprod_t           dp_reg [3];
    m3inv_pkg::cof_t  cofc_reg [9];
    logic [3:0]       vld_reg;

    assign m[0][0] = mat.a00;
    assign m[0][1] = mat.a01;
    assign m[0][2] = mat.a02;
    assign m[1][0] = mat.a10;
    assign m[1][1] = mat.a11;
    assign m[1][2] = mat.a12;
    assign m[2][0] = mat.a20;
    assign m[2][1] = mat.a21;
    assign m[2][2] = mat.a22;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p1_reg[3*i+j] <= m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3];
                p2_reg[3*i+j] <= m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
            end
            row0_reg[i] <= m[0][i];
        end
        for (int k = 0; k < 9; k++)
        begin
            cof_reg[k] <= m3inv_pkg::CofWidth'(p1_reg[k]) - m3inv_pkg::CofWidth'(p2_reg[k]);
        end
        row0b_reg <= row0_reg;
        for (int k = 0; k < 3; k++)
        begin
            pl_reg[k] <= pprod_t'(row0b_reg[k])
                       * pprod_t'($signed({1'b0, cof_reg[k][m3inv_pkg::DataWidth-1:0]}));
            ph_reg[k] <= pprod_t'(row0b_reg[k])
                       * pprod_t'($signed(cof_reg[k][m3inv_pkg::CofWidth-1:
                                                     m3inv_pkg::DataWidth]));
        end
        cofb_reg <= cof_reg;
        for (int k = 0; k < 3; k++)
        begin
            dp_reg[k] <= (dprod_t'(ph_reg[k]) <<< m3inv_pkg::DataWidth) + dprod_t'(pl_reg[k]);
        end
        cofc_reg <= cofb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[3];
    assign det = dp_reg[0] + dp_reg[1] + dp_reg[2];
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            cof[k] = cofc_reg[k];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/m3inv_div.sv */
// One lane: pipelined restoring divider, one quotient bit per stage, with saturation.
`default_nettype none
module m3inv_div (
    input  wire logic                                  clk,
    input  wire m3inv_pkg::lane_in_t                   lane_in,
    input  wire logic [m3inv_pkg::DivMagW-1:0]         den,
    output m3inv_pkg::lane_out_t                       lane_out
);

    localparam int QW = m3inv_pkg::QuotWidth;
    localparam int RW = m3inv_pkg::DivMagW + 1;

    logic [RW-1:0]                  rem_reg [QW+1];
    logic [QW-1:0]                  num_reg [QW+1];
    logic [m3inv_pkg::DivMagW-1:0]  den_reg [QW+1];
    logic                           neg_reg [QW+1];
    logic [RW-1:0]                  rem_sh [QW];
    logic [QW-1:0]                  q;
    logic [QW-1:0]                  lim;

    always_comb
    begin
        for (int s = 0; s < QW; s++)
        begin
            rem_sh[s] = {rem_reg[s][RW-2:0], num_reg[s][QW-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        num_reg[0] <= lane_in.num_mag;
        den_reg[0] <= den;
        neg_reg[0] <= lane_in.neg;
        for (int s = 0; s < QW; s++)
        begin
            if (rem_sh[s] >= {1'b0, den_reg[s]})
            begin
                rem_reg[s+1] <= rem_sh[s] - {1'b0, den_reg[s]};
                num_reg[s+1] <= {num_reg[s][QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= rem_sh[s];
                num_reg[s+1] <= {num_reg[s][QW-2:0], 1'b0};
            end
            den_reg[s+1] <= den_reg[s];
            neg_reg[s+1] <= neg_reg[s];
        end
    end

    assign q = num_reg[QW];
    assign lim = neg_reg[QW] ? (QW'(1) << (m3inv_pkg::DataWidth - 1))
                             : ((QW'(1) << (m3inv_pkg::DataWidth - 1)) - QW'(1));

    always_comb
    begin
        if (q > lim)
        begin
            lane_out.sat   = 1'b1;
            lane_out.value = neg_reg[QW] ? m3inv_pkg::elem_t'(-lim)
                                         : m3inv_pkg::elem_t'(lim);
        end
        else
        begin
            lane_out.sat   = 1'b0;
            lane_out.value = neg_reg[QW] ? m3inv_pkg::elem_t'(-q)
                                         : m3inv_pkg::elem_t'(q);
        end
    end

endmodule
`default_nettype wire

/* test/matrix_3x3_inverse_core_tb.sv */
// Testbench for the 3x3 matrix inverse core: directed and random matrices checked by a predictor.
`default_nettype none
module matrix_3x3_inverse_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = 103;
    localparam logic signed [31:0] EMax = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] EMin = 32'sh8000_0000;
    localparam logic signed [31:0] One  = 32'sh0001_0000;

    typedef struct {
        m3inv_pkg::mat_in_t  mat;
        logic                known;
        m3inv_pkg::mat_out_t want;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    m3inv_pkg::mat_in_t  mat_in;
    logic                done;
    m3inv_pkg::mat_out_t mat_out;

    m3inv_pkg::mat_out_t inverse_q[$];
    int       mismatches;
    int       beats_in;
    int       beats_out;
    int       singular_seen;
    int       saturated_seen;

    matrix_3x3_inverse_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .mat_in  (mat_in),
        .done    (done),
        .mat_out (mat_out)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [31:0] sat_quot(logic signed [255:0] num,
                                                    logic signed [255:0] den,
                                                    inout logic sat);
        logic [255:0] un;
        logic [255:0] ud;
        logic [255:0] q;
        logic         neg;
        neg = num[255] ^ den[255];
        un  = num[255] ? -num : num;
        ud  = den[255] ? -den : den;
        q   = un / ud;
        if (!neg && q > 256'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return EMax;
        end
        if (neg && q > 256'h8000_0000)
        begin
            sat = 1'b1;
            return EMin;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic m3inv_pkg::mat_out_t invert_matrix(m3inv_pkg::mat_in_t m);
        logic signed [255:0] a [3][3];
        logic signed [255:0] cof [3][3];
        logic signed [255:0] det;
        logic signed [31:0]  res [3][3];
        logic                sat;
        m3inv_pkg::mat_out_t r;
        a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
        a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
        a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                          - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
        det = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
        r = '0;
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        sat = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                res[j][i] = sat_quot(cof[i][j] <<< (2 * m3inv_pkg::FracBits), det, sat);
        r.b00 = res[0][0]; r.b01 = res[0][1]; r.b02 = res[0][2];
        r.b10 = res[1][0]; r.b11 = res[1][1]; r.b12 = res[1][2];
        r.b20 = res[2][0]; r.b21 = res[2][1]; r.b22 = res[2][2];
        r.saturated = sat;
        return r;
    endfunction

    function automatic m3inv_pkg::mat_in_t diag(logic signed [31:0] x, logic signed [31:0] y,
                                                logic signed [31:0] z);
        m3inv_pkg::mat_in_t m;
        m = '0;
        m.a00 = x;
        m.a11 = y;
        m.a22 = z;
        return m;
    endfunction

    function automatic logic signed [31:0] rand_elem(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $signed($urandom_range(0, 32'h0000_0200)) - 32'sh0000_0100;
            default: return ($urandom_range(0, 1) != 0) ? EMax : EMin;
        endcase
    endfunction

    function automatic m3inv_pkg::mat_in_t rand_matrix();
        m3inv_pkg::mat_in_t m;
        int      mode;
        mode = $urandom_range(0, 9);
        mode = (mode < 3) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
        m.a00 = rand_elem(mode); m.a01 = rand_elem(mode); m.a02 = rand_elem(mode);
        m.a10 = rand_elem(mode); m.a11 = rand_elem(mode); m.a12 = rand_elem(mode);
        m.a20 = rand_elem(mode); m.a21 = rand_elem(mode); m.a22 = rand_elem(mode);
        if ($urandom_range(0, 15) == 0)
        begin
            m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
        end
        return m;
    endfunction

    task automatic send_matrix(m3inv_pkg::mat_in_t m, logic known,
                               m3inv_pkg::mat_out_t want, logic gaps);
        m3inv_pkg::mat_out_t pred;
        pred = invert_matrix(m);
        if (known && pred !== want)
        begin
            mismatches++;
            $display("Table entry disagrees with predictor: table %h, predicted %h", want, pred);
        end
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        start  <= 1'b1;
        mat_in <= m;
        @(posedge clk);
        while (busy) @(posedge clk);
        inverse_q.push_back(pred);
        beats_in++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            beats_out++;
            if (mat_out.singular) singular_seen++;
            if (mat_out.saturated) saturated_seen++;
            if (inverse_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat: %h", mat_out);
            end
            else
            begin
                m3inv_pkg::mat_out_t w;
                w = inverse_q.pop_front();
                if (mat_out !== w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch on beat %0d: expected %h, got %h",
                                 beats_out, w, mat_out);
                end
            end
        end
    end

    initial
    begin
        dir_row_t            rows[$];
        m3inv_pkg::mat_out_t z;
        m3inv_pkg::mat_out_t w;
        m3inv_pkg::mat_in_t  m;
        int                  idle;

        start      = 1'b0;
        mat_in     = '0;
        rst_n      = 1'b0;
        mismatches = 0;
        beats_in   = 0;
        beats_out  = 0;
        singular_seen  = 0;
        saturated_seen = 0;

        z = '0;
        z.singular = 1'b1;
        rows.push_back('{mat: '0, known: 1'b1, want: z});
        w = '0;
        w.b00 = One; w.b11 = One; w.b22 = One;
        rows.push_back('{mat: diag(One, One, One), known: 1'b1, want: w});
        w = '0;
        w.b00 = -One; w.b11 = -One; w.b22 = -One;
        rows.push_back('{mat: diag(-One, -One, -One), known: 1'b1, want: w});
        w = '0;
        w.b00 = EMax; w.b11 = EMax; w.b22 = EMax; w.saturated = 1'b1;
        rows.push_back('{mat: diag(32'sd1, 32'sd1, 32'sd1), known: 1'b1, want: w});
        w = '0;
        w.b00 = EMin; w.b11 = EMin; w.b22 = EMin; w.saturated = 1'b1;
        rows.push_back('{mat: diag(-32'sd1, -32'sd1, -32'sd1), known: 1'b1, want: w});
        rows.push_back('{mat: diag(EMax, EMax, EMax), known: 1'b0, want: z});
        rows.push_back('{mat: diag(EMin, EMin, EMin), known: 1'b0, want: z});
        rows.push_back('{mat: diag(EMin, EMax, -32'sd1), known: 1'b0, want: z});
        rows.push_back('{mat: {9{EMax}}, known: 1'b1, want: z});
        rows.push_back('{mat: {9{EMin}}, known: 1'b1, want: z});
        rows.push_back('{mat: {9{32'hFFFF_FFFF}}, known: 1'b1, want: z});
        rows.push_back('{mat: diag(32'sh0002_0000, 32'sh0004_0000, 32'shFFFF_8000),
                         known: 1'b0, want: z});
        m = diag(One, One, One);
        m.a01 = 32'sh0003_0000; m.a12 = 32'shFFFE_0000; m.a20 = 32'sh0000_8000;
        rows.push_back('{mat: m, known: 1'b0, want: z});
        m = '{a00: EMax, a01: EMin, a02: One, a10: 32'sh5555_5555, a11: 32'shAAAA_AAAA,
              a12: -One, a20: 32'sd3, a21: 32'sh0F0F_0F0F, a22: 32'shF0F0_F0F0};
        rows.push_back('{mat: m, known: 1'b0, want: z});

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[k])
            send_matrix(rows[k].mat, rows[k].known, rows[k].want, 1'b0);

        start <= 1'b0;
        while (inverse_q.size() != 0) @(negedge clk);

        for (int n = 0; n < 2000; n++)
        begin
            idle = (n < 1700) ? 1 : 0;
            send_matrix(rand_matrix(), 1'b0, z, idle[0]);
            if (n == 900)
            begin
                start <= 1'b0;
                while (inverse_q.size() != 0) @(negedge clk);
            end
        end
        start <= 1'b0;

        while (inverse_q.size() != 0) @(negedge clk);
        repeat (Latency + 10) @(negedge clk);

        $display("Matrices sent: %0d, results checked: %0d (singular %0d, saturated %0d).",
                 beats_in, beats_out, singular_seen, saturated_seen);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("Mismatches: %0d", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout waiting for results.");
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

/* matrix_3x3_inverse_core.f */
rtl/core/m3inv_pkg.sv
rtl/core/m3inv_cof.sv
rtl/core/m3inv_div.sv
rtl/core/matrix_3x3_inverse_core.sv
test/matrix_3x3_inverse_core_tb.sv
